/* rtl/core/cfrd_pkg.sv */
// ============================================================================
// cfrd_pkg
// Shared types and constants of the capture file record deframer.
// ============================================================================
package cfrd_pkg;

    localparam logic [31:0] MAGIC_BIG        = 32'ha1b2c3d4;
    localparam logic [31:0] MAGIC_LITTLE     = 32'hd4c3b2a1;
    localparam logic [31:0] USEC_SLACK_LIMIT = 32'd1000100;
    localparam logic [31:0] USEC_NEG_FLOOR   = 32'hFFFFFF00;
    localparam logic [31:0] USEC_PER_SEC     = 32'd1000000;
    localparam logic [19:0] USEC_PER_SEC_20  = 20'd1000000;
    localparam logic [17:0] MAX_FRAME_RESET  = 18'd131072;
    localparam logic [31:0] MIN_WIRE_BYTES   = 32'd8;

    localparam int unsigned FILE_HDR_BYTES   = 24;
    localparam int unsigned REC_HDR_BYTES    = 16;

    typedef enum logic [1:0] {
        KIND_FILE    = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    localparam logic ERR_MAGIC   = 1'b0;
    localparam logic ERR_CORRUPT = 1'b1;

    // One classified request passed from the front end to the back end.
    typedef struct packed {
        t_kind       kind;
        logic        code;      // error code on an error request
        logic        big;       // byte order on a file header request
        logic        last;
        logic        borrow;    // microseconds are a small negative value
        logic        carry;     // microseconds slightly over one second
        logic [31:0] word;      // link type, seconds, or payload byte
        logic [19:0] micros;
        logic [17:0] cap;
        logic [17:0] wire_len;
    } t_entry;

endpackage

/* rtl/core/cfrd_front.sv */
// ============================================================================
// cfrd_front
// Accept file bytes, gather headers, check them and classify each request.
// ============================================================================
module cfrd_front import cfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_file_byte,
    input  logic [17:0] i_max_frame,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    typedef enum logic [3:0] {
        PH_FILE   = 4'b0001,
        PH_RECORD = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_HALT   = 4'b1000
    } t_phase;

    localparam logic [4:0] FILE_LAST = 5'(FILE_HDR_BYTES - 1);
    localparam logic [4:0] REC_LAST  = 5'(REC_HDR_BYTES - 1);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [17:0] r_left, n_left;
    logic        r_big, n_big;
    logic [7:0]  r_hdr [FILE_HDR_BYTES];
    logic        hdr_we;

    logic        accept;
    logic [31:0] magic, link_raw, secs, usecs, cap, wlen;
    logic        file_big, file_little;
    logic        usec_hi, usec_neg, usec_over, bad;

    function automatic logic [31:0] make_word(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic big);
        return big ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    assign accept = i_valid && !i_full;

    assign magic       = {r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3]};
    assign file_big    = (magic == MAGIC_BIG);
    assign file_little = (magic == MAGIC_LITTLE);
    assign link_raw    = make_word(r_hdr[20], r_hdr[21], r_hdr[22], i_file_byte, file_big);

    assign secs  = make_word(r_hdr[0],  r_hdr[1],  r_hdr[2],  r_hdr[3],    r_big);
    assign usecs = make_word(r_hdr[4],  r_hdr[5],  r_hdr[6],  r_hdr[7],    r_big);
    assign cap   = make_word(r_hdr[8],  r_hdr[9],  r_hdr[10], r_hdr[11],   r_big);
    assign wlen  = make_word(r_hdr[12], r_hdr[13], r_hdr[14], i_file_byte, r_big);

    assign usec_hi   = usecs > USEC_SLACK_LIMIT;
    assign usec_neg  = usecs > USEC_NEG_FLOOR;
    assign usec_over = usecs > USEC_PER_SEC;
    assign bad = (usec_hi && !usec_neg)
              || (cap  > {14'd0, i_max_frame})
              || (wlen > {14'd0, i_max_frame})
              || (wlen < cap)
              || (wlen < MIN_WIRE_BYTES);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_left  = r_left;
        n_big   = r_big;
        hdr_we  = 1'b0;
        o_push  = 1'b0;
        o_entry = '0;
        if (accept) begin
            unique case (r_phase)
                PH_FILE: begin
                    hdr_we = 1'b1;
                    n_pos  = r_pos + 5'd1;
                    if (r_pos == FILE_LAST) begin
                        n_pos  = '0;
                        o_push = 1'b1;
                        if (file_big || file_little) begin
                            n_big         = file_big;
                            o_entry.kind  = KIND_FILE;
                            o_entry.big   = file_big;
                            o_entry.word  = link_raw;
                            n_phase       = PH_RECORD;
                        end else begin
                            o_entry.kind = KIND_ERROR;
                            o_entry.code = ERR_MAGIC;
                            n_phase      = PH_HALT;
                        end
                    end
                end
                PH_RECORD: begin
                    hdr_we = 1'b1;
                    n_pos  = r_pos + 5'd1;
                    if (r_pos == REC_LAST) begin
                        n_pos  = '0;
                        o_push = 1'b1;
                        if (bad) begin
                            o_entry.kind = KIND_ERROR;
                            o_entry.code = ERR_CORRUPT;
                            n_phase      = PH_HALT;
                        end else begin
                            o_entry.kind     = KIND_RECORD;
                            o_entry.borrow   = usec_hi;
                            o_entry.carry    = !usec_hi && usec_over;
                            o_entry.word     = secs;
                            o_entry.micros   = usecs[19:0];
                            o_entry.cap      = cap[17:0];
                            o_entry.wire_len = wlen[17:0];
                            o_entry.last     = (cap == 32'd0);
                            n_left           = cap[17:0];
                            n_phase          = (cap == 32'd0) ? PH_RECORD : PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    o_push       = 1'b1;
                    n_left       = r_left - 18'd1;
                    o_entry.kind = KIND_PAYLOAD;
                    o_entry.word = {24'd0, i_file_byte};
                    o_entry.last = (r_left == 18'd1);
                    if (r_left == 18'd1) begin
                        n_phase = PH_RECORD;
                        n_pos   = '0;
                    end
                end
                PH_HALT: begin
                    // drop everything until reset
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FILE;
            r_pos   <= '0;
            r_left  <= '0;
            r_big   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_big   <= n_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_pos] <= i_file_byte;
        end
    end

endmodule

/* rtl/core/cfrd_fifo.sv */
// ============================================================================
// cfrd_fifo
// Two-entry queue of classified requests between front and back end.
// ============================================================================
module cfrd_fifo import cfrd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_empty
);

    t_entry     r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = ~r_wr;
        end
        if (i_pop) begin
            n_rd = ~r_rd;
        end
        unique case ({i_push, i_pop})
            2'b10: begin
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_count = r_count - 2'd1;
            end
            2'b00, 2'b11: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/core/cfrd_back.sv */
// ============================================================================
// cfrd_back
// Normalize timestamps, fill in stream context and hold the output register.
// ============================================================================
module cfrd_back import cfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_entry,
    input  logic        i_empty,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic        o_big_endian,
    output logic [31:0] o_link_id,
    output logic [31:0] o_stamp_seconds,
    output logic [19:0] o_stamp_micros,
    output logic [17:0] o_captured_bytes,
    output logic [17:0] o_wire_bytes,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic        o_error_code
);

    logic        r_valid, n_valid;
    logic        r_big, n_big;
    logic [31:0] r_link, n_link;

    logic [1:0]  r_kind, n_kind;
    logic        r_obig, n_obig;
    logic [31:0] r_olink, n_olink;
    logic [31:0] r_secs, n_secs;
    logic [19:0] r_usec, n_usec;
    logic [17:0] r_cap, n_cap;
    logic [17:0] r_wire, n_wire;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        r_code, n_code;

    assign o_pop = !i_empty && (!r_valid || !i_stall);

    always_comb begin
        n_valid = r_valid && i_stall;
        n_big   = r_big;
        n_link  = r_link;
        n_kind  = r_kind;
        n_obig  = r_obig;
        n_olink = r_olink;
        n_secs  = r_secs;
        n_usec  = r_usec;
        n_cap   = r_cap;
        n_wire  = r_wire;
        n_byte  = r_byte;
        n_last  = r_last;
        n_code  = r_code;
        if (o_pop) begin
            n_valid = 1'b1;
            n_kind  = i_entry.kind;
            n_obig  = r_big;
            n_olink = r_link;
            n_secs  = '0;
            n_usec  = '0;
            n_cap   = '0;
            n_wire  = '0;
            n_byte  = '0;
            n_last  = 1'b0;
            n_code  = 1'b0;
            unique case (i_entry.kind)
                KIND_FILE: begin
                    n_big   = i_entry.big;
                    n_link  = (i_entry.word == 32'd0) ? 32'd1 : i_entry.word;
                    n_obig  = n_big;
                    n_olink = n_link;
                end
                KIND_RECORD: begin
                    n_cap  = i_entry.cap;
                    n_wire = i_entry.wire_len;
                    n_last = i_entry.last;
                    priority if (i_entry.borrow) begin
                        n_secs = i_entry.word - 32'd1;
                        n_usec = i_entry.micros + USEC_PER_SEC_20;
                    end else if (i_entry.carry) begin
                        n_secs = i_entry.word + 32'd1;
                        n_usec = i_entry.micros - USEC_PER_SEC_20;
                    end else begin
                        n_secs = i_entry.word;
                        n_usec = i_entry.micros;
                    end
                end
                KIND_PAYLOAD: begin
                    n_byte = i_entry.word[7:0];
                    n_last = i_entry.last;
                end
                KIND_ERROR: begin
                    n_obig  = 1'b0;
                    n_olink = '0;
                    n_code  = i_entry.code;
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_big   <= 1'b0;
            r_link  <= '0;
        end else begin
            r_valid <= n_valid;
            r_big   <= n_big;
            r_link  <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_obig  <= n_obig;
        r_olink <= n_olink;
        r_secs  <= n_secs;
        r_usec  <= n_usec;
        r_cap   <= n_cap;
        r_wire  <= n_wire;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_code  <= n_code;
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_big_endian     = r_obig;
    assign o_link_id        = r_olink;
    assign o_stamp_seconds  = r_secs;
    assign o_stamp_micros   = r_usec;
    assign o_captured_bytes = r_cap;
    assign o_wire_bytes     = r_wire;
    assign o_payload_byte   = r_byte;
    assign o_last           = r_last;
    assign o_error_code     = r_code;

endmodule

/* rtl/core/capture_file_record_deframer_core.sv */
// ============================================================================
// capture_file_record_deframer_core
// Split a capture file byte stream into file header, record headers and
// payload bytes, with header checks and timestamp normalization.
// ============================================================================
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  input    | in        | i_valid / o_stall    | i_file_byte
//  output   | out       | o_valid / i_stall    | o_kind .. o_error_code
//  config   | in        | i_cfg_we             | i_cfg_data (max_frame_bytes)
//
//  One byte is taken per clock while o_stall is low. A request reaches the
//  output register via the queue: the front end writes the queue at the
//  accepting edge and the output register loads from it when it is empty
//  or the output side does not stall. Header bytes give no result until the
//  last header byte; the 2-entry queue carries one request per clock, so
//  o_stall rises only when the output side stalls. Synchronous active-low
//  reset returns to the file header phase with max_frame_bytes at 131072.
//  After an error request, bytes are still taken and dropped until reset.
//
module capture_file_record_deframer_core import cfrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_file_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic        o_big_endian,
    output logic [31:0] o_link_id,
    output logic [31:0] o_stamp_seconds,
    output logic [19:0] o_stamp_micros,
    output logic [17:0] o_captured_bytes,
    output logic [17:0] o_wire_bytes,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic        o_error_code
);

    logic [17:0] r_max_frame;
    logic        push, pop, full, empty;
    t_entry      push_entry, head_entry;

    // Hold the frame length limit; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
        end else if (i_cfg_we) begin
            r_max_frame <= i_cfg_data;
        end
    end

    // Stall the input only when the queue has no room.
    assign o_stall = full;

    // Front end: gather headers, check them, count payload bytes.
    cfrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_file_byte (i_file_byte),
        .i_max_frame (r_max_frame),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Queue: decouple the front end from output stalls.
    cfrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back end: normalize timestamps and drive the output register.
    cfrd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (head_entry),
        .i_empty          (empty),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_big_endian     (o_big_endian),
        .o_link_id        (o_link_id),
        .o_stamp_seconds  (o_stamp_seconds),
        .o_stamp_micros   (o_stamp_micros),
        .o_captured_bytes (o_captured_bytes),
        .o_wire_bytes     (o_wire_bytes),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .o_error_code     (o_error_code)
    );

endmodule
